/* rtl/core/heading_steering_controller_core_defines.svh */
// Assertion macros shared by the core.
`ifndef HEADING_STEERING_CONTROLLER_CORE_DEFINES_SVH
`define HEADING_STEERING_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/hsc_pkg.sv */
package hsc_pkg;

   localparam int FUNC_W     = 4;
   localparam int HEAD_W     = 9;
   localparam int PRIO_W     = 4;
   localparam int GAIN_W     = 10;
   localparam int CMD_W      = 16;
   localparam int ERR_W      = 10;
   localparam int DIFF_W     = 11;
   localparam int SUM_W      = 20;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int NUM_SENDERS_DEFAULT = 8;

   localparam logic [FUNC_W-1:0] FUNC_MEASURE    = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_TARGET = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_LEFT90     = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_RIGHT90    = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_TURN180    = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_DISABLE    = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_ENABLE     = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_REPORT     = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_SET_MIN    = 4'd8;
   localparam logic [FUNC_W-1:0] FUNC_RESET_MIN  = 4'd9;

   localparam logic KIND_STEER  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [1:0] REG_GAIN   = 2'd0;
   localparam logic [1:0] REG_CENTER = 2'd1;
   localparam logic [1:0] REG_LOWER  = 2'd2;
   localparam logic [1:0] REG_UPPER  = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_RESET   = 10'd250;
   localparam logic [CMD_W-1:0]  CENTER_RESET = 16'd15000;
   localparam logic [CMD_W-1:0]  LOWER_RESET  = 16'd10000;
   localparam logic [CMD_W-1:0]  UPPER_RESET  = 16'd20000;

   localparam logic [HEAD_W:0] QUARTER_TURN = 10'd90;
   localparam logic [HEAD_W:0] HALF_TURN    = 10'd180;
   localparam logic [HEAD_W:0] FULL_TURN    = 10'd360;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [CMD_W-1:0]  center_offset;
      logic [CMD_W-1:0]  lower_limit;
      logic [CMD_W-1:0]  upper_limit;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [HEAD_W-1:0] heading_deg;
      logic [PRIO_W-1:0] sender_priority;
   } item_type;

   typedef struct packed {
      logic              has_result;
      logic              kind;
      logic [HEAD_W-1:0] target;
   } step_type;

endpackage

/* rtl/core/hsc_csr.sv */
module hsc_csr
   import hsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GAIN:   cfg_in.gain          = csr_pwdata[GAIN_W-1:0];
            REG_CENTER: cfg_in.center_offset = csr_pwdata[CMD_W-1:0];
            REG_LOWER:  cfg_in.lower_limit   = csr_pwdata[CMD_W-1:0];
            REG_UPPER:  cfg_in.upper_limit   = csr_pwdata[CMD_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GAIN:   csr_prdata = CSR_DATA_W'(cfg_ff.gain);
         REG_CENTER: csr_prdata = CSR_DATA_W'(cfg_ff.center_offset);
         REG_LOWER:  csr_prdata = CSR_DATA_W'(cfg_ff.lower_limit);
         REG_UPPER:  csr_prdata = CSR_DATA_W'(cfg_ff.upper_limit);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain          <= GAIN_RESET;
         cfg_ff.center_offset <= CENTER_RESET;
         cfg_ff.lower_limit   <= LOWER_RESET;
         cfg_ff.upper_limit   <= UPPER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/hsc_state.sv */
module hsc_state
   import hsc_pkg::*;
#(
   parameter int NUM_SENDERS = NUM_SENDERS_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  item_type item,
   input  logic     fire,
   output step_type step
);

   localparam logic [PRIO_W-1:0] MIN_PRIO_RESET = PRIO_W'(NUM_SENDERS);

   logic [HEAD_W-1:0] target_ff, target_in;
   logic              active_ff, active_in;
   logic [PRIO_W-1:0] min_prio_ff, min_prio_in;
   logic              prio_ok;
   logic [HEAD_W:0]   right_sum, half_sum;
   logic [HEAD_W-1:0] left_turn, right_turn, half_turn;

   assign prio_ok = item.sender_priority <= min_prio_ff;

   // Turns keep one wrap correction only; 360 itself may stay.
   assign right_sum  = {1'b0, target_ff} + QUARTER_TURN;
   assign half_sum   = {1'b0, target_ff} + HALF_TURN;
   assign left_turn  = ({1'b0, target_ff} < QUARTER_TURN)
                     ? HEAD_W'({1'b0, target_ff} + FULL_TURN - QUARTER_TURN)
                     : HEAD_W'({1'b0, target_ff} - QUARTER_TURN);
   assign right_turn = (right_sum > FULL_TURN) ? HEAD_W'(right_sum - FULL_TURN)
                                               : right_sum[HEAD_W-1:0];
   assign half_turn  = (half_sum > FULL_TURN) ? HEAD_W'(half_sum - FULL_TURN)
                                              : half_sum[HEAD_W-1:0];

   always_comb begin
      target_in   = target_ff;
      active_in   = active_ff;
      min_prio_in = min_prio_ff;
      if (fire && item.func != FUNC_MEASURE && prio_ok) begin
         case (item.func)
            FUNC_SET_TARGET: target_in   = item.heading_deg;
            FUNC_LEFT90:     target_in   = left_turn;
            FUNC_RIGHT90:    target_in   = right_turn;
            FUNC_TURN180:    target_in   = half_turn;
            FUNC_DISABLE:    active_in   = 1'b0;
            FUNC_ENABLE:     active_in   = 1'b1;
            FUNC_SET_MIN:    min_prio_in = item.sender_priority;
            FUNC_RESET_MIN:  min_prio_in = MIN_PRIO_RESET;
            default:         target_in   = target_ff;
         endcase
      end
   end

   always_comb begin
      step.target = target_ff;
      if (item.func == FUNC_MEASURE) begin
         step.has_result = active_ff;
         step.kind       = KIND_STEER;
      end else begin
         step.has_result = (item.func == FUNC_REPORT) && prio_ok;
         step.kind       = KIND_REPORT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         active_ff   <= 1'b1;
         min_prio_ff <= MIN_PRIO_RESET;
      end else begin
         target_ff   <= target_in;
         active_ff   <= active_in;
         min_prio_ff <= min_prio_in;
      end
   end

endmodule

/* rtl/core/hsc_steer.sv */
module hsc_steer
   import hsc_pkg::*;
(
   input  logic [HEAD_W-1:0] heading_deg,
   input  logic [HEAD_W-1:0] target,
   input  cfg_type           cfg,
   output logic [CMD_W-1:0]  steering_command
);

   logic signed [DIFF_W-1:0] diff, diff_wrap;
   logic signed [ERR_W-1:0]  err;
   logic signed [SUM_W-1:0]  err_x, gain_x, prod, sum, upper_x, lower_x;

   assign diff = $signed({2'b00, heading_deg}) - $signed({2'b00, target});

   always_comb begin
      if (diff > $signed({1'b0, HALF_TURN}))
         diff_wrap = diff - $signed({1'b0, FULL_TURN});
      else if (diff < -$signed({1'b0, HALF_TURN}))
         diff_wrap = diff + $signed({1'b0, FULL_TURN});
      else
         diff_wrap = diff;
   end

   // Wrapped error stays within +/-180.
   assign err     = diff_wrap[ERR_W-1:0];
   assign err_x   = SUM_W'(err);
   assign gain_x  = $signed(SUM_W'(cfg.gain));
   assign prod    = err_x * gain_x;
   assign sum     = prod + $signed(SUM_W'(cfg.center_offset));
   assign upper_x = $signed(SUM_W'(cfg.upper_limit));
   assign lower_x = $signed(SUM_W'(cfg.lower_limit));

   always_comb begin
      if (sum > upper_x)
         steering_command = cfg.upper_limit;
      else if (sum < lower_x)
         steering_command = cfg.lower_limit;
      else
         steering_command = sum[CMD_W-1:0];
   end

endmodule

/* rtl/core/heading_steering_controller_core.sv */
// Pipeline: an item with a result goes from the input register through the
// steering/command stage into the result register, which drives rsp_valid.
// Throughput: one item per cycle unless a stalled result holds an item back;
// the single compute stage and the result register set the rate, and a stalled
// result holds back only the input register.
// Reset (synchronous, active high): target 0, enabled, minimum priority
// NUM_SENDERS, registers at their defaults, both pipeline registers empty.
`include "heading_steering_controller_core_defines.svh"

module heading_steering_controller_core
   import hsc_pkg::*;
#(
   parameter int NUM_SENDERS = NUM_SENDERS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [HEAD_W-1:0]     req_heading_deg,
   input  logic [PRIO_W-1:0]     req_sender_priority,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_kind,
   output logic [CMD_W-1:0]      rsp_steering_command,
   output logic [HEAD_W-1:0]     rsp_target_heading,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg;
   step_type          step;
   item_type          item_ff, item_in;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              kind_ff, kind_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [HEAD_W-1:0] out_target_ff, out_target_in;
   logic [CMD_W-1:0]  steer_cmd;
   logic              accept, fire, load_out;

   hsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hsc_state #(
      .NUM_SENDERS (NUM_SENDERS)
   ) u_state (
      .clock (clock),
      .reset (reset),
      .item  (item_ff),
      .fire  (fire),
      .step  (step)
   );

   hsc_steer u_steer (
      .heading_deg      (item_ff.heading_deg),
      .target           (step.target),
      .cfg              (cfg),
      .steering_command (steer_cmd)
   );

   // An item with no result retires even while the result register is stalled.
   assign fire      = in_valid_ff && (!step.has_result || !out_valid_ff || !rsp_stall);
   assign load_out  = fire && step.has_result;
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         item_in.func            = req_func;
         item_in.heading_deg     = req_heading_deg;
         item_in.sender_priority = req_sender_priority;
         in_valid_in             = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      kind_in       = kind_ff;
      cmd_in        = cmd_ff;
      out_target_in = out_target_ff;
      if (load_out) begin
         out_valid_in  = 1'b1;
         kind_in       = step.kind;
         cmd_in        = (step.kind == KIND_REPORT) ? '0 : steer_cmd;
         out_target_in = step.target;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      kind_ff       <= kind_in;
      cmd_ff        <= cmd_in;
      out_target_ff <= out_target_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_steering_command = cmd_ff;
   assign rsp_target_heading   = out_target_ff;

   `HSC_ASSERT_NOW(a_report_zero_cmd, clock, reset,
      rsp_valid && rsp_kind == KIND_REPORT, rsp_steering_command == '0,
      "report item carries a nonzero steering command")
   `HSC_ASSERT_NOW(a_cmd_clamped, clock, reset,
      rsp_valid && rsp_kind == KIND_STEER,
      rsp_steering_command == cfg.upper_limit || rsp_steering_command == cfg.lower_limit ||
      (rsp_steering_command >= cfg.lower_limit && rsp_steering_command <= cfg.upper_limit),
      "steering command outside the limits")
   `HSC_ASSERT_NEXT(a_held_item_kept, clock, reset,
      in_valid_ff && !fire, in_valid_ff,
      "item in the input register lost without retiring")
   `HSC_ASSERT_NOW(a_stall_cause, clock, reset,
      req_stall, in_valid_ff && out_valid_ff && rsp_stall && step.has_result,
      "input stalled without a blocked result")

endmodule
